// File: design/spta_pkg.sv
// Shared types and codes for the sparse polynomial term accumulator.
package spta_pkg;

   localparam int COEFF_W = 32;
   localparam int FIELD_W = 8;

   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_DUMP  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_LIST = 2'd2;

   typedef struct packed {
      logic [1:0]                op;
      logic [FIELD_W-1:0]        exp_x;
      logic [FIELD_W-1:0]        exp_y;
      logic [FIELD_W-1:0]        exp_z;
      logic signed [COEFF_W-1:0] term_coeff;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [FIELD_W-1:0]        out_x;
      logic [FIELD_W-1:0]        out_y;
      logic [FIELD_W-1:0]        out_z;
      logic signed [COEFF_W-1:0] out_coeff;
      logic                      last;
   } rsp_type;

   // Flags from the compare and add unit back to the sequencer.
   typedef struct packed {
      logic gt;
      logic eq;
      logic sum_zero;
   } cmp_type;

endpackage

// File: design/spta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/spta_unit.sv
// Shared key compare and saturating coefficient adder.
module spta_unit
   import spta_pkg::*;
#(
   parameter int KEY_W = 24
) (
   input  logic [KEY_W-1:0]          key_a,
   input  logic [KEY_W-1:0]          key_b,
   input  logic signed [COEFF_W-1:0] coeff_a,
   input  logic signed [COEFF_W-1:0] coeff_b,
   output logic signed [COEFF_W-1:0] sum,
   output cmp_type                   flags
);

   logic signed [COEFF_W:0] wide_sum;

   always_comb begin
      wide_sum = {coeff_a[COEFF_W-1], coeff_a} + {coeff_b[COEFF_W-1], coeff_b};
      // Clamp when the two top bits disagree.
      if (wide_sum[COEFF_W] != wide_sum[COEFF_W-1]) begin
         sum = wide_sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
      end else begin
         sum = wide_sum[COEFF_W-1:0];
      end
      flags.gt       = (key_a > key_b);
      flags.eq       = (key_a == key_b);
      flags.sum_zero = (sum == '0);
   end

endmodule

// File: design/sparse_polynomial_term_accumulator.sv
// Top level: sorted term table, sequencer and result register.
// Accumulate: one pass over the table RAM
//   (one entry read per cycle, search and shift in the same pass).
// Dump: each listed term goes through S_DWAIT, then S_DSEND until the result side takes it.
// Clear: no result. One transaction at a time; ready only when idle.
// Reset (synchronous, active high) empties the table and idles the sequencer.
module sparse_polynomial_term_accumulator
   import spta_pkg::*;
#(
   parameter int MAX_TERMS = 32,
   parameter int EXP_BITS  = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int KEY_W  = 3 * EXP_BITS;
   localparam int DATA_W = KEY_W + COEFF_W;
   localparam int ADDR_W = $clog2(MAX_TERMS);
   localparam int CNT_W  = $clog2(MAX_TERMS + 1);

   typedef enum logic [2:0] {S_IDLE, S_ACC, S_RESP, S_DWAIT, S_DSEND} state_type;
   typedef enum logic [1:0] {M_SEARCH, M_INSERT, M_DELETE} mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;     // next entry to read
   logic [CNT_W-1:0] pidx_ff, pidx_in;     // entry whose data is on the read port
   logic             pv_ff, pv_in;
   logic [CNT_W-1:0] dk_ff, dk_in;         // entry being listed
   logic [KEY_W-1:0] key_ff, key_in;
   logic signed [COEFF_W-1:0] coeff_ff, coeff_in;
   logic [DATA_W-1:0] hold_ff, hold_in;    // entry displaced by an insert
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic [KEY_W-1:0]          rd_key;
   logic signed [COEFF_W-1:0] rd_coeff;
   logic signed [COEFF_W-1:0] sum;
   cmp_type                   flags;

   assign rd_key   = rd_data[DATA_W-1:COEFF_W];
   assign rd_coeff = rd_data[COEFF_W-1:0];

   spta_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_TERMS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   spta_unit #(
      .KEY_W(KEY_W)
   ) u_unit (
      .key_a  (rd_key),
      .key_b  (key_ff),
      .coeff_a(rd_coeff),
      .coeff_b(coeff_ff),
      .sum    (sum),
      .flags  (flags)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      rcnt_in      = rcnt_ff;
      pidx_in      = pidx_ff;
      pv_in        = pv_ff;
      dk_in        = dk_ff;
      key_in       = key_ff;
      coeff_in     = coeff_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            // Read address zero is primed here so a dump finds its first entry ready.
            if (req_valid) begin
               case (req_data.op)
                  OP_ACCUM: begin
                     key_in   = {EXP_BITS'(req_data.exp_x), EXP_BITS'(req_data.exp_y),
                                 EXP_BITS'(req_data.exp_z)};
                     coeff_in = req_data.term_coeff;
                     rcnt_in  = '0;
                     pv_in    = 1'b0;
                     mode_in  = M_SEARCH;
                     state_in = S_ACC;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        // Empty table: one zero term, marked last.
                        rsp_in        = '0;
                        rsp_in.status = ST_LIST;
                        rsp_in.last   = 1'b1;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_RESP;
                     end else begin
                        dk_in    = '0;
                        state_in = S_DWAIT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // Unused code: drop the transaction.
                  end
               endcase
            end
         end

         S_ACC: begin
            rd_addr = rcnt_ff[ADDR_W-1:0];
            if (rcnt_ff < count_ff) begin
               rcnt_in = rcnt_ff + 1'b1;
               pidx_in = rcnt_ff;
               pv_in   = 1'b1;
            end else begin
               pv_in = 1'b0;
            end

            rsp_in      = '0;
            rsp_in.last = 1'b1;

            if (pv_ff) begin
               case (mode_ff)
                  M_SEARCH: begin
                     if (flags.eq) begin
                        if (flags.sum_zero) begin
                           mode_in = M_DELETE;
                        end else begin
                           wr_en        = 1'b1;
                           wr_addr      = pidx_ff[ADDR_W-1:0];
                           wr_data      = {key_ff, sum};
                           rsp_in.status = ST_OK;
                           rsp_valid_in = 1'b1;
                           state_in     = S_RESP;
                        end
                     end else if (!flags.gt) begin
                        // Insertion point found.
                        if (coeff_ff == '0) begin
                           rsp_in.status = ST_OK;
                           rsp_valid_in  = 1'b1;
                           state_in      = S_RESP;
                        end else if (count_ff == CNT_W'(MAX_TERMS)) begin
                           rsp_in.status = ST_FULL;
                           rsp_valid_in  = 1'b1;
                           state_in      = S_RESP;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = pidx_ff[ADDR_W-1:0];
                           wr_data = {key_ff, coeff_ff};
                           hold_in = rd_data;
                           mode_in = M_INSERT;
                        end
                     end
                  end
                  M_INSERT: begin
                     // Ripple each entry one place down.
                     wr_en   = 1'b1;
                     wr_addr = pidx_ff[ADDR_W-1:0];
                     wr_data = hold_ff;
                     hold_in = rd_data;
                  end
                  M_DELETE: begin
                     // Close the gap left by the removed term.
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(pidx_ff - 1'b1);
                     wr_data = rd_data;
                  end
                  default: begin
                     mode_in = M_SEARCH;
                  end
               endcase
            end else if (rcnt_ff == count_ff) begin
               // Pass complete: settle the tail of the table.
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OK;
               state_in      = S_RESP;
               case (mode_ff)
                  M_SEARCH: begin
                     if (coeff_ff != '0) begin
                        if (count_ff == CNT_W'(MAX_TERMS)) begin
                           rsp_in.status = ST_FULL;
                        end else begin
                           wr_en    = 1'b1;
                           wr_addr  = count_ff[ADDR_W-1:0];
                           wr_data  = {key_ff, coeff_ff};
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  M_INSERT: begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[ADDR_W-1:0];
                     wr_data  = hold_ff;
                     count_in = count_ff + 1'b1;
                  end
                  M_DELETE: begin
                     count_in = count_ff - 1'b1;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end

         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         S_DWAIT: begin
            rsp_in.status    = ST_LIST;
            rsp_in.out_x     = FIELD_W'(rd_key[KEY_W-1:2*EXP_BITS]);
            rsp_in.out_y     = FIELD_W'(rd_key[2*EXP_BITS-1:EXP_BITS]);
            rsp_in.out_z     = FIELD_W'(rd_key[EXP_BITS-1:0]);
            rsp_in.out_coeff = rd_coeff;
            rsp_in.last      = ((dk_ff + 1'b1) == count_ff);
            rsp_valid_in     = 1'b1;
            state_in         = S_DSEND;
         end

         S_DSEND: begin
            // Keep the next entry's read in flight while the result waits.
            rd_addr = ADDR_W'(dk_ff + 1'b1);
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  dk_in    = dk_ff + 1'b1;
                  state_in = S_DWAIT;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_SEARCH;
         count_ff     <= '0;
         rcnt_ff      <= '0;
         pidx_ff      <= '0;
         pv_ff        <= 1'b0;
         dk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rcnt_ff      <= rcnt_in;
         pidx_ff      <= pidx_in;
         pv_ff        <= pv_in;
         dk_ff        <= dk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff   <= key_in;
      coeff_ff <= coeff_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("term count beyond table size");

   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result is pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready)
      else $error("not idle after final result");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.op == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear left terms in the table");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |=> (count_ff == $past(count_ff)
                               || count_ff == $past(count_ff) + 1'b1
                               || count_ff == $past(count_ff) - 1'b1))
      else $error("accumulate changed count by more than one");
`endif

endmodule

// File: sim/spta_term_checker.sv
// Checker for the term accumulator: shadows the sorted term table and compares every response.
module spta_term_checker
   import spta_pkg::*;
#(
   parameter int MAX_TERMS = 32,
   parameter int EXP_BITS  = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      due_count
);

   localparam int     KEY_W   = 3 * EXP_BITS;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   logic [KEY_W-1:0]          shadow_key   [MAX_TERMS];
   logic signed [COEFF_W-1:0] shadow_coeff [MAX_TERMS];
   int                        shadow_count;
   rsp_type                   due_terms [$];
   int                        mismatches;

   function automatic logic signed [COEFF_W-1:0] clamp_sum(
      input logic signed [COEFF_W-1:0] a,
      input logic signed [COEFF_W-1:0] b
   );
      longint s;
      s = longint'(a) + longint'(b);
      if (s > SUM_MAX) s = SUM_MAX;
      else if (s < SUM_MIN) s = SUM_MIN;
      return s[COEFF_W-1:0];
   endfunction

   // Merge one term into the shadow table; report the status it earns.
   task automatic add_term(
      input  logic [KEY_W-1:0]          key,
      input  logic signed [COEFF_W-1:0] c,
      output logic [1:0]                st
   );
      int                        i;
      int                        j;
      logic signed [COEFF_W-1:0] s;
      i  = 0;
      st = ST_OK;
      while (i < shadow_count && shadow_key[i] > key) i++;
      if (i < shadow_count && shadow_key[i] == key) begin
         s = clamp_sum(shadow_coeff[i], c);
         if (s == 0) begin
            for (j = i; j < shadow_count - 1; j++) begin
               shadow_key[j]   = shadow_key[j+1];
               shadow_coeff[j] = shadow_coeff[j+1];
            end
            shadow_count--;
         end else begin
            shadow_coeff[i] = s;
         end
      end else if (c == 0) begin
         st = ST_OK;
      end else if (shadow_count >= MAX_TERMS) begin
         st = ST_FULL;
      end else begin
         for (j = shadow_count; j > i; j--) begin
            shadow_key[j]   = shadow_key[j-1];
            shadow_coeff[j] = shadow_coeff[j-1];
         end
         shadow_key[i]   = key;
         shadow_coeff[i] = c;
         shadow_count++;
      end
   endtask

   task automatic absorb_request(input req_type t);
      logic [KEY_W-1:0] key;
      logic [1:0]       st;
      rsp_type          r;
      int               i;
      case (t.op)
         OP_ACCUM: begin
            key = {t.exp_x[EXP_BITS-1:0], t.exp_y[EXP_BITS-1:0], t.exp_z[EXP_BITS-1:0]};
            add_term(key, t.term_coeff, st);
            r        = '0;
            r.status = st;
            r.last   = 1'b1;
            due_terms.push_back(r);
         end
         OP_DUMP: begin
            if (shadow_count == 0) begin
               r        = '0;
               r.status = ST_LIST;
               r.last   = 1'b1;
               due_terms.push_back(r);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  r           = '0;
                  r.status    = ST_LIST;
                  r.out_x     = FIELD_W'(shadow_key[i][3*EXP_BITS-1 -: EXP_BITS]);
                  r.out_y     = FIELD_W'(shadow_key[i][2*EXP_BITS-1 -: EXP_BITS]);
                  r.out_z     = FIELD_W'(shadow_key[i][EXP_BITS-1:0]);
                  r.out_coeff = shadow_coeff[i];
                  r.last      = (i == shadow_count - 1);
                  due_terms.push_back(r);
               end
            end
         end
         OP_CLEAR: shadow_count = 0;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatches < 10)
         $display("[%0t] %s: expected st=%0d x=%0d y=%0d z=%0d c=%0d last=%0d, got st=%0d x=%0d y=%0d z=%0d c=%0d last=%0d",
                  $time, what, want.status, want.out_x, want.out_y, want.out_z,
                  want.out_coeff, want.last, got.status, got.out_x, got.out_y,
                  got.out_z, got.out_coeff, got.last);
      mismatches++;
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         shadow_count = 0;
         due_terms.delete();
      end else begin
         // responses first: whatever is accepted now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (due_terms.size() == 0) begin
               report_mismatch("response with nothing due", '0, rsp_data);
            end else begin
               want = due_terms.pop_front();
               if (want.status !== rsp_data.status || want.out_x !== rsp_data.out_x ||
                   want.out_y !== rsp_data.out_y || want.out_z !== rsp_data.out_z ||
                   want.out_coeff !== rsp_data.out_coeff || want.last !== rsp_data.last)
                  report_mismatch("response differs", want, rsp_data);
            end
         end
         if (req_valid && req_ready) absorb_request(req_data);
      end
      mismatch_count <= mismatches;
      due_count      <= due_terms.size();
   end

endmodule

// File: sim/sparse_polynomial_term_accumulator_tb.sv
// Testbench top: drives requests and response back-pressure, and gives the verdict.
module sparse_polynomial_term_accumulator_tb;
   import spta_pkg::*;

   localparam int          CYCLE_LIMIT = 4000000;
   localparam int          LONG_HOLD   = 400;
   localparam int          DRAIN_WAIT  = 80;
   localparam int          RANDOM_REQS = 420;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam logic signed [COEFF_W-1:0] COEFF_MAX = 32'sh7fffffff;
   localparam logic signed [COEFF_W-1:0] COEFF_MIN = 32'sh80000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int      mismatch_count;
   int      due_count;

   // Shared between the two driving processes.
   bit      steady;         // suppress every gap on both sides
   bit      hold_rsp_side;  // ask the response side for one long hold-off

   sparse_polynomial_term_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   spta_term_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .due_count      (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none, often a short gap, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic req_type term(
      input logic [1:0]                op,
      input int                        x,
      input int                        y,
      input int                        z,
      input logic signed [COEFF_W-1:0] c
   );
      req_type t;
      t.op         = op;
      t.exp_x      = FIELD_W'(x);
      t.exp_y      = FIELD_W'(y);
      t.exp_z      = FIELD_W'(z);
      t.term_coeff = c;
      return t;
   endfunction

   // Random request: a narrow exponent span gives frequent matches, small
   // coefficients give frequent cancellation, clear_pct sets how often the table is wiped.
   function automatic req_type random_req(input int span, input int clear_pct);
      req_type                   t;
      int                        r;
      logic signed [COEFF_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 5) t.op = OP_UNUSED;
      else if (r < 5 + clear_pct) t.op = OP_CLEAR;
      else if (r < 17 + clear_pct) t.op = OP_DUMP;
      else t.op = OP_ACCUM;
      t.exp_x = FIELD_W'($urandom_range(0, span));
      t.exp_y = FIELD_W'($urandom_range(0, span));
      t.exp_z = FIELD_W'($urandom_range(0, span));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         c = int'($urandom_range(0, 6)) - 3;
      end else if (r < 60) begin
         case ($urandom_range(0, 3))
            0: c = COEFF_MAX;
            1: c = COEFF_MIN;
            2: c = 1;
            default: c = -1;
         endcase
      end else begin
         c = $urandom;
      end
      t.term_coeff = c;
      return t;
   endfunction

   // Present one transaction after a random gap and hold it until accepted.
   // Valid is left high on return so that back-to-back requests need no toggle.
   task automatic offer(input req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until the checker has nothing outstanding.
   // The count is registered, so step the clock before looking at it.
   task automatic wait_settled();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_side) begin
            hold_rsp_side = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: give up once the cycle count passes a generous ceiling.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("sparse_polynomial_term_accumulator verification failed");
      $finish;
   end

   initial begin
      req_type t;
      int      counted;
      int      span;
      int      clear_pct;
      int      i;
      int      phase;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      steady        = 1'b0;
      hold_rsp_side = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty dump, exponent and coefficient extremes, saturation
      // both ways, zero term with no partner, cancellation, ordering on each
      // exponent, unused op code and clear.
      offer(term(OP_DUMP, 0, 0, 0, 0));
      offer(term(OP_ACCUM, 255, 255, 255, COEFF_MAX));
      offer(term(OP_ACCUM, 0, 0, 0, COEFF_MIN));
      offer(term(OP_ACCUM, 255, 255, 255, 1));
      offer(term(OP_ACCUM, 0, 0, 0, -1));
      offer(term(OP_ACCUM, 5, 5, 5, 0));
      offer(term(OP_ACCUM, 1, 2, 3, 7));
      offer(term(OP_ACCUM, 1, 2, 3, -7));
      offer(term(OP_ACCUM, 1, 0, 0, 4));
      offer(term(OP_ACCUM, 0, 255, 255, -4));
      offer(term(OP_ACCUM, 0, 1, 0, 9));
      offer(term(OP_ACCUM, 0, 0, 1, -9));
      offer(term(OP_ACCUM, 0, 0, 0, COEFF_MAX));
      offer(term(OP_DUMP, 0, 0, 0, 0));
      offer(term(OP_UNUSED, 255, 255, 255, -1));
      offer(term(OP_DUMP, 0, 0, 0, 0));
      offer(term(OP_CLEAR, 0, 0, 0, 0));
      offer(term(OP_DUMP, 0, 0, 0, 0));
      offer(term(OP_UNUSED, 0, 0, 0, 0));
      wait_settled();

      // Full table: fill all entries, then stall the response side for a long
      // stretch while requests keep coming so the block backs up.
      offer(term(OP_CLEAR, 0, 0, 0, 0));
      for (i = 0; i < 32; i++) offer(term(OP_ACCUM, i, 31 - i, 7, i + 1));
      hold_rsp_side = 1'b1;
      offer(term(OP_ACCUM, 200, 1, 1, 5));    // no partner, no room: dropped
      offer(term(OP_ACCUM, 3, 28, 7, 10));    // partner present: still added
      offer(term(OP_ACCUM, 201, 0, 0, 0));    // zero with no partner: accepted
      offer(term(OP_ACCUM, 0, 31, 7, -1));    // cancels an entry, frees a slot
      offer(term(OP_DUMP, 0, 0, 0, 0));
      offer(term(OP_ACCUM, 200, 1, 1, 5));    // now fits
      offer(term(OP_DUMP, 0, 0, 0, 0));
      wait_settled();

      // Random phases: few keys with frequent matches, enough keys to fill the
      // table with no clears, a gap-free stretch, then fully random exponents.
      counted = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin span = 1;   clear_pct = 3; end
            1: begin span = 3;   clear_pct = 0; end
            2: begin span = 2;   clear_pct = 2; end
            default: begin span = 255; clear_pct = 3; end
         endcase
         steady = (phase == 2);
         while (counted < (phase + 1) * RANDOM_REQS / 4) begin
            t = random_req(span, clear_pct);
            offer(t);
            if (t.op != OP_UNUSED) counted++;
         end
         wait_settled();
      end
      steady = 1'b0;

      // Let any trailing clear finish, then give the verdict.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && due_count == 0)
         $display("sparse_polynomial_term_accumulator verification clean");
      else
         $display("sparse_polynomial_term_accumulator verification failed");
      $finish;
   end

endmodule

// File: sim.f
design/spta_pkg.sv
design/spta_ram.sv
design/spta_unit.sv
design/sparse_polynomial_term_accumulator.sv
sim/spta_term_checker.sv
sim/sparse_polynomial_term_accumulator_tb.sv
